/* rtl/core/pal_pkg.sv */
// Shared types and constants of the positional array list.
package pal_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned MovesW  = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned GroupSz = 16;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic                     ins_ok;
    logic                     del_ok;
    logic [PosW-1:0]          pos;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

/* rtl/core/pal_if.sv */
// Request and response channel interfaces of the positional array list.
interface pal_req_if;
  import pal_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [0:0]               kind;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pal_rsp_if;
  import pal_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [ValueW-1:0] removed_value;
  logic [MovesW-1:0]        moves;
  logic [CountW-1:0]        count_after;

  modport source (output valid, status, removed_value, moves, count_after, input ready);
  modport sink   (input valid, status, removed_value, moves, count_after, output ready);
endinterface

/* rtl/core/pal_cell.sv */
// One list entry: holds, loads, or shifts from a neighbor; taps its value at the delete point.
module pal_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                              clk_i,
  input  pal_pkg::cell_cmd_t                cmd_i,
  input  logic signed [pal_pkg::ValueW-1:0] left_i,
  input  logic signed [pal_pkg::ValueW-1:0] right_i,
  output logic signed [pal_pkg::ValueW-1:0] data_o,
  output logic signed [pal_pkg::ValueW-1:0] tap_o
);
  import pal_pkg::*;

  localparam int unsigned IdxBits = (Idx > 0) ? $clog2(Idx + 1) : 1;
  localparam int unsigned CmpW    = (IdxBits > PosW) ? IdxBits : PosW;
  localparam logic [CmpW-1:0] IdxV = CmpW'(Idx);

  logic signed [ValueW-1:0] data_q, data_d;
  logic [CmpW-1:0]          pos_x;
  logic                     at_pos, above_pos;

  assign pos_x     = CmpW'(cmd_i.pos);
  assign at_pos    = (pos_x == IdxV);
  assign above_pos = (IdxV > pos_x);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins_ok) begin
      if (at_pos) begin
        data_d = cmd_i.value;
      end else if (above_pos) begin
        data_d = left_i;
      end
    end else if (cmd_i.del_ok) begin
      if (at_pos || above_pos) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (cmd_i.del_ok && at_pos) ? data_q : '0;

endmodule

/* rtl/core/positional_array_list_top.sv */
// Top level of the positional array list: cell chain, count control and removed-value tree.
//
//  channel | dir | fields                                        | beat when
//  req_i   | in  | kind, position, value                         | valid && ready
//  rsp_o   | out | status, removed_value, moves, count_after     | valid && ready
//
// One request per cycle unless responses stall; results pass stage 1 and the output stage.
// Cells from the position up shift as the request is taken; the removed value passes
// through a two-level registered OR tree (groups of 16 cells, then the groups).
// Reset clears the entry count and the valid flags; entry contents start unknown.
// A stalled response holds its beat; requests stall while it does and stage 1 is full.
module positional_array_list_top #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  pal_req_if.sink   req_i,
  pal_rsp_if.source rsp_o
);
  import pal_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned NGrp  = (CAPACITY + GroupSz - 1) / GroupSz;
  localparam logic [CmpW-1:0] CapV = CmpW'(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] pos_x, cnt_x, mv;
  logic            acc, ins_ok, del_ok;
  status_e         status;
  cell_cmd_t       cmd;

  logic                      s1_valid_q, s1_del_q, s1_adv;
  status_e                   s1_status_q;
  logic [MovesW-1:0]         s1_moves_q;
  logic [CountW-1:0]         s1_count_q;
  logic signed [ValueW-1:0]  s1_grp_q [NGrp];
  logic signed [ValueW-1:0]  grp_or [NGrp];

  logic                      out_valid_q;
  status_e                   out_status_q;
  logic signed [ValueW-1:0]  out_rem_q, rem_or;
  logic [MovesW-1:0]         out_moves_q;
  logic [CountW-1:0]         out_count_q;

  logic signed [ValueW-1:0]  cell_data [CAPACITY];
  logic [GroupSz-1:0][ValueW-1:0] tap_g [NGrp];

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign acc         = req_i.valid && req_i.ready;

  assign pos_x = CmpW'(req_i.position);
  assign cnt_x = CmpW'(count_q);

  always_comb begin
    status  = ST_OK;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    mv      = '0;
    count_d = count_q;
    if (kind_e'(req_i.kind) == KIND_INSERT) begin
      if (cnt_x == CapV) begin
        status = ST_FULL;
      end else if (pos_x > cnt_x) begin
        status = ST_BADPOS;
      end else begin
        ins_ok  = 1'b1;
        mv      = cnt_x - pos_x;
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (cnt_x == '0) begin
        status = ST_EMPTY;
      end else if (pos_x >= cnt_x) begin
        status = ST_BADPOS;
      end else begin
        del_ok  = 1'b1;
        mv      = cnt_x - pos_x - CmpW'(1);
        count_d = count_q - CntW'(1);
      end
    end
  end

  assign cmd.ins_ok = acc && ins_ok;
  assign cmd.del_ok = acc && del_ok;
  assign cmd.pos    = req_i.position;
  assign cmd.value  = req_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left, right, tap;
    if (i == 0) begin : g_first
      assign left = req_i.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pal_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .tap_o  (tap)
    );
    assign tap_g[i / GroupSz][i % GroupSz] = tap;
  end

  for (genvar j = CAPACITY; j < NGrp * GroupSz; j++) begin : g_pad
    assign tap_g[j / GroupSz][j % GroupSz] = '0;
  end

  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GroupSz; k++) begin
        grp_or[g] = grp_or[g] | tap_g[g][k];
      end
    end
  end

  always_comb begin
    rem_or = '0;
    for (int g = 0; g < NGrp; g++) begin
      rem_or = rem_or | s1_grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
      end
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_status_q <= status;
      s1_del_q    <= del_ok;
      s1_moves_q  <= MovesW'(mv);
      s1_count_q  <= CountW'(count_d);
      s1_grp_q    <= grp_or;
    end
    if (s1_adv && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_rem_q    <= s1_del_q ? rem_or : '0;
      out_moves_q  <= s1_moves_q;
      out_count_q  <= s1_count_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_value = out_rem_q;
  assign rsp_o.moves         = out_moves_q;
  assign rsp_o.count_after   = out_count_q;

endmodule
